// ===== rtl/mbvq_ed_pkg.sv =====
// shared constants, types and decision functions of the mbvq color halftoner
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package mbvq_ed_pkg;

	localparam int unsigned LINE_MAX_DEF = 1024;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned VTX_W      = 3;
	localparam int unsigned LEN_CFG_W  = 11;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;

	// error widths: e is -255..255, carry 7e, line entry at most 9*255
	localparam int unsigned E_W     = 9;
	localparam int unsigned CARRY_W = 12;
	localparam int unsigned ERR_W   = 13;
	localparam int unsigned ACC_W   = 14;
	localparam int unsigned ADJ_W   = 10;
	localparam int unsigned VAL_W   = 11;

	localparam logic [LEN_CFG_W-1:0] ROW_LENGTH_RST = 11'd640;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SERPENTINE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 2'd2;

	// diffusion weights in sixteenths
	localparam logic signed [3:0] W_NEXT   = 4'sd7;
	localparam logic signed [3:0] W_BEHIND = 4'sd3;
	localparam logic signed [3:0] W_BELOW  = 4'sd5;

	localparam logic [PIX_W-1:0] FULL = 8'd255;

	// vertex codes
	localparam logic [VTX_W-1:0] V_BLACK   = 3'd0;
	localparam logic [VTX_W-1:0] V_BLUE    = 3'd1;
	localparam logic [VTX_W-1:0] V_RED     = 3'd2;
	localparam logic [VTX_W-1:0] V_GREEN   = 3'd3;
	localparam logic [VTX_W-1:0] V_MAGENTA = 3'd4;
	localparam logic [VTX_W-1:0] V_CYAN    = 3'd5;
	localparam logic [VTX_W-1:0] V_YELLOW  = 3'd6;
	localparam logic [VTX_W-1:0] V_WHITE   = 3'd7;

	// minimum-brightness quadruples
	localparam logic [2:0] Q_CMYW = 3'd1;
	localparam logic [2:0] Q_MYGC = 3'd2;
	localparam logic [2:0] Q_RGMY = 3'd3;
	localparam logic [2:0] Q_KRGB = 3'd4;
	localparam logic [2:0] Q_RGBM = 3'd5;
	localparam logic [2:0] Q_CMGB = 3'd6;

	typedef logic [PIX_W-1:0] pix_t;

	// vertex code to {r, g, b} bits
	function automatic logic [2:0] vtx_bits(input logic [VTX_W-1:0] v);
		logic [2:0] b;
		unique case (v)
			V_BLACK:   b = 3'b000;
			V_BLUE:    b = 3'b001;
			V_RED:     b = 3'b100;
			V_GREEN:   b = 3'b010;
			V_MAGENTA: b = 3'b101;
			V_CYAN:    b = 3'b011;
			V_YELLOW:  b = 3'b110;
			default:   b = 3'b111;
		endcase
		return b;
	endfunction

	function automatic logic [2:0] pick_quad(input pix_t r, input pix_t g, input pix_t b);
		logic [8:0] rg;
		logic [8:0] gb;
		logic [9:0] rgb;
		logic [2:0] q;
		rg  = {1'b0, r} + {1'b0, g};
		gb  = {1'b0, g} + {1'b0, b};
		rgb = {2'b0, r} + {2'b0, g} + {2'b0, b};
		if (rg > 9'd255) begin
			if (gb > 9'd255) q = (rgb > 10'd510) ? Q_CMYW : Q_MYGC;
			else q = Q_RGMY;
		end else begin
			if (gb <= 9'd255) q = (rgb <= 10'd255) ? Q_KRGB : Q_RGBM;
			else q = Q_CMGB;
		end
		return q;
	endfunction

	// half thresholds: 2x > 255 and 2x >= 255 both mean x >= 128
	function automatic logic [VTX_W-1:0] pick_vertex(input logic [2:0] q, input pix_t r,
			input pix_t g, input pix_t b);
		logic              hr;
		logic              hg;
		logic              hb;
		logic [8:0]        br;
		logic signed [10:0] rgb_d;
		logic [VTX_W-1:0]  v;
		hr    = r[PIX_W-1];
		hg    = g[PIX_W-1];
		hb    = b[PIX_W-1];
		br    = {1'b0, b} + {1'b0, r};
		rgb_d = $signed({3'b0, r}) - $signed({3'b0, g}) + $signed({3'b0, b});
		v     = V_BLACK;
		unique case (q)
			Q_CMYW: begin
				v = V_WHITE;
				if (!hb && b <= r && b <= g) v = V_YELLOW;
				if (!hg && g <= b && g <= r) v = V_MAGENTA;
				if (!hr && r <= b && r <= g) v = V_CYAN;
			end
			Q_MYGC: begin
				v = V_MAGENTA;
				if (g >= b && r >= b) v = hr ? V_YELLOW : V_GREEN;
				if (g >= r && b >= r) v = hb ? V_CYAN : V_GREEN;
			end
			Q_RGMY: begin
				if (hb) begin
					if (hr) v = (b >= g) ? V_MAGENTA : V_YELLOW;
					else v = ({1'b0, g} > br) ? V_GREEN : V_MAGENTA;
				end else begin
					if (hr) v = hg ? V_YELLOW : V_RED;
					else v = (r >= g) ? V_RED : V_GREEN;
				end
			end
			Q_KRGB: begin
				v = V_BLACK;
				if (hb && b >= r && b >= g) v = V_BLUE;
				if (hg && g >= b && g >= r) v = V_GREEN;
				if (hr && r >= b && r >= g) v = V_RED;
			end
			Q_RGBM: begin
				v = V_GREEN;
				if (r > g && r >= b) v = !hb ? V_RED : V_MAGENTA;
				if (b > g && b >= r) v = !hr ? V_BLUE : V_MAGENTA;
			end
			default: begin
				if (hb) begin
					if (hr) v = (g >= r) ? V_CYAN : V_MAGENTA;
					else v = hg ? V_CYAN : V_BLUE;
				end else begin
					if (hr) v = (rgb_d >= 11'sd128) ? V_MAGENTA : V_GREEN;
					else v = (g >= b) ? V_GREEN : V_BLUE;
				end
			end
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/mbvq_ed_ifs.sv =====
// valid/ready channel interfaces: pixel input, result output, register writes
// depends on mbvq_ed_pkg for field widths
`timescale 1ns / 1ps

interface mbvq_ed_pix_if import mbvq_ed_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	logic             frame_start;

	modport source (output valid, red, green, blue, frame_start, input ready);
	modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface mbvq_ed_res_if import mbvq_ed_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VTX_W-1:0] vertex;
	logic             red_on;
	logic             green_on;
	logic             blue_on;

	modport source (output valid, vertex, red_on, green_on, blue_on, input ready);
	modport sink (input valid, vertex, red_on, green_on, blue_on, output ready);
endinterface

interface mbvq_ed_cfg_if import mbvq_ed_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mbvq_color_error_diffusion_top.sv =====
// mbvq color halftoner with floyd-steinberg error diffusion through a column line store
// depends on mbvq_ed_pkg and the channel interfaces in mbvq_ed_ifs.sv
//
//   channel   dir   payload                                  transfer when
//   cfg       in    index, data                              valid & ready (ready always 1)
//   pixel     in    red, green, blue, frame_start            valid & ready
//   result    out   vertex, red_on, green_on, blue_on        valid & ready
//
// one pixel per clock sustained while result.ready stays high; a result passes stage 1 and
// the result register before it is offered
// the rate is set by the carry loop (next-pixel error feeds the following pixel) and
// the single line store, read once per pixel and written at most once per edge
// after reset a clearing pass zeroes every line store entry while pixel.ready is held low
// a stalled result register holds stage 1, which in turn holds pixel.ready low
`timescale 1ns / 1ps

module mbvq_color_error_diffusion_top import mbvq_ed_pkg::*; #(
	parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
	input logic          clk,
	input logic          arst_n,
	mbvq_ed_cfg_if.sink  cfg,
	mbvq_ed_pix_if.sink  pixel,
	mbvq_ed_res_if.source result
);

	localparam int unsigned CW = $clog2(LINE_MAX);
	localparam int unsigned LW = (CW + 1 > LEN_CFG_W) ? CW + 1 : LEN_CFG_W;
	localparam int unsigned MW = 3 * ERR_W;

	// configuration registers
	logic [LEN_CFG_W-1:0] row_length_q;
	logic                 serpentine_q;
	logic                 invert_q;

	// row position, updated at each pixel transfer
	logic [CW-1:0] column_q;
	logic          row_odd_q;
	logic          first_row_q;

	// line store clearing pass
	logic          clr_q;
	logic [CW-1:0] clr_addr_q;

	// line store: three channel errors per column
	logic [MW-1:0] line_mem [LINE_MAX];
	logic [MW-1:0] line_rd_s1;

	// write port
	logic          wr_en;
	logic [CW-1:0] wr_addr;
	logic [MW-1:0] wr_data;

	// deferred end-of-row write, drained on the following edge
	logic          endp_valid_q;
	logic [CW-1:0] endp_addr_q;
	logic [MW-1:0] endp_data_q;

	// diffusion state
	logic signed [CARRY_W-1:0] carry_q   [3];
	logic signed [ERR_W-1:0]   pend_a_q  [3];
	logic signed [ERR_W-1:0]   pend_b_q  [3];

	// accept-side address generation
	logic [LW-1:0] rl_ext;
	logic [CW-1:0] len_m1;
	logic [CW-1:0] col_f;
	logic [CW-1:0] c_a;
	logic          row_odd_f;
	logic          first_f;
	logic          rev_a;
	logic [CW-1:0] x_a;
	logic [CW-1:0] xb_a;
	logic          last_a;
	logic          in_acc;

	// stage 1
	logic             valid_s1;
	pix_t             pix_s1 [3];
	logic [CW-1:0]    x_s1;
	logic [CW-1:0]    xb_s1;
	logic             below_s1;
	logic             last_s1;
	logic             first_col_s1;
	logic             first_row_s1;
	logic             fwd_s1;
	logic [MW-1:0]    fwd_data_s1;
	logic             adv_s1;

	// stage 1 datapath
	logic [MW-1:0]             line_raw;
	logic signed [ERR_W-1:0]   line_v  [3];
	logic signed [CARRY_W-1:0] carry_v [3];
	logic signed [ERR_W-1:0]   pa_v    [3];
	logic signed [ERR_W-1:0]   pb_v    [3];
	logic signed [ACC_W-1:0]   acc     [3];
	logic signed [ACC_W-1:0]   acc8    [3];
	logic signed [ADJ_W-1:0]   adj     [3];
	logic signed [VAL_W-1:0]   val     [3];
	pix_t                      sat_v   [3];
	logic signed [E_W-1:0]     e_v     [3];
	logic signed [CARRY_W-1:0] carry_n [3];
	logic signed [ERR_W-1:0]   pa_n    [3];
	logic signed [ERR_W-1:0]   below_w [3];
	logic [2:0]                quad;
	logic [VTX_W-1:0]          vtx;
	logic [2:0]                vbits;

	// result register
	logic             valid_s2;
	logic [VTX_W-1:0] vertex_s2;
	logic             red_on_s2;
	logic             green_on_s2;
	logic             blue_on_s2;

	// ---------------------------------------------------------------- configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RST;
			serpentine_q <= 1'b1;
			invert_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ROW_LENGTH: row_length_q <= cfg.data;
				CFG_SERPENTINE: serpentine_q <= cfg.data[0];
				CFG_INVERT:     invert_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- address generation
	// effective row length minus one: zero counts as one, long rows cap at the line size
	assign rl_ext = LW'(row_length_q);

	always_comb begin
		if (rl_ext == '0) len_m1 = '0;
		else if (rl_ext > LW'(LINE_MAX)) len_m1 = CW'(LINE_MAX - 1);
		else len_m1 = CW'(rl_ext - LW'(1));
	end

	// frame start restarts the row count and masks stored error
	assign col_f     = pixel.frame_start ? '0 : column_q;
	assign row_odd_f = pixel.frame_start ? 1'b0 : row_odd_q;
	assign first_f   = pixel.frame_start | first_row_q;
	// a shorter row length set mid row clamps the column to the new last one
	assign c_a       = (col_f <= len_m1) ? col_f : len_m1;
	assign rev_a     = serpentine_q & row_odd_f;
	assign x_a       = rev_a ? (len_m1 - c_a) : c_a;
	assign xb_a      = rev_a ? (x_a + CW'(1)) : (x_a - CW'(1));
	assign last_a    = (c_a == len_m1);

	assign in_acc      = pixel.valid && pixel.ready;
	assign adv_s1      = valid_s1 && (!valid_s2 || result.ready);
	assign pixel.ready = !clr_q && (!valid_s1 || adv_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			row_odd_q   <= 1'b0;
			first_row_q <= 1'b1;
		end else if (in_acc) begin
			if (last_a) begin
				column_q    <= '0;
				row_odd_q   <= ~row_odd_f;
				first_row_q <= 1'b0;
			end else begin
				column_q    <= c_a + CW'(1);
				row_odd_q   <= row_odd_f;
				first_row_q <= first_f;
			end
		end
	end

	// ---------------------------------------------------------------- clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + CW'(1);
			if (clr_addr_q == CW'(LINE_MAX - 1)) clr_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- line store
	// one write per edge: the end-of-row write only ever follows a row end, when the
	// next pixel sits at column zero and writes nothing itself
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = xb_s1;
		wr_data = {below_w[2], below_w[1], below_w[0]};
		priority if (clr_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (endp_valid_q) begin
			wr_en   = 1'b1;
			wr_addr = endp_addr_q;
			wr_data = endp_data_q;
		end else if (adv_s1 && below_s1) begin
			wr_en   = 1'b1;
		end else begin
			wr_en   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) line_mem[wr_addr] <= wr_data;
		if (in_acc) line_rd_s1 <= line_mem[x_a];
	end

	// ---------------------------------------------------------------- stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_acc) valid_s1 <= 1'b1;
		else if (adv_s1) valid_s1 <= 1'b0;
	end

	// a write landing on this column at the read edge, or while the pixel waits,
	// replaces the stale read data
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1[0]    <= pixel.red;
			pix_s1[1]    <= pixel.green;
			pix_s1[2]    <= pixel.blue;
			x_s1         <= x_a;
			xb_s1        <= xb_a;
			below_s1     <= (c_a != '0);
			last_s1      <= last_a;
			first_col_s1 <= (c_a == '0);
			first_row_s1 <= first_f;
			fwd_s1       <= wr_en && (wr_addr == x_a);
			fwd_data_s1  <= wr_data;
		end else if (valid_s1 && wr_en && (wr_addr == x_s1)) begin
			fwd_s1      <= 1'b1;
			fwd_data_s1 <= wr_data;
		end
	end

	// ---------------------------------------------------------------- stage 1 datapath
	// the pending end-of-row entry is the newest copy of its column
	always_comb begin
		if (endp_valid_q && (endp_addr_q == x_s1)) line_raw = endp_data_q;
		else if (fwd_s1) line_raw = fwd_data_s1;
		else line_raw = line_rd_s1;
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			line_v[ch]  = first_row_s1 ? '0 : $signed(line_raw[ch*ERR_W +: ERR_W]);
			carry_v[ch] = first_col_s1 ? '0 : carry_q[ch];
			pa_v[ch]    = first_col_s1 ? '0 : pend_a_q[ch];
			pb_v[ch]    = first_col_s1 ? '0 : pend_b_q[ch];
			// round sixteenths to the nearest whole, ties toward plus infinity
			acc[ch]     = ACC_W'(carry_v[ch]) + ACC_W'(line_v[ch]);
			acc8[ch]    = acc[ch] + $signed(ACC_W'(8));
			adj[ch]     = ADJ_W'(acc8[ch] >>> 4);
			val[ch]     = $signed({3'b0, pix_s1[ch]}) + VAL_W'(adj[ch]);
			if (val[ch] < 0) sat_v[ch] = '0;
			else if (val[ch] > $signed({3'b0, FULL})) sat_v[ch] = FULL;
			else sat_v[ch] = val[ch][PIX_W-1:0];
		end
		quad  = pick_quad(sat_v[0], sat_v[1], sat_v[2]);
		vtx   = pick_vertex(quad, sat_v[0], sat_v[1], sat_v[2]);
		vbits = vtx_bits(vtx);
		for (int ch = 0; ch < 3; ch++) begin
			e_v[ch]     = $signed({1'b0, sat_v[ch]}) -
				(vbits[2-ch] ? $signed({1'b0, FULL}) : $signed(E_W'(0)));
			carry_n[ch] = CARRY_W'(e_v[ch]) * CARRY_W'(W_NEXT);
			pa_n[ch]    = pb_v[ch] + ERR_W'(e_v[ch]) * ERR_W'(W_BELOW);
			below_w[ch] = pa_v[ch] + ERR_W'(e_v[ch]) * ERR_W'(W_BEHIND);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < 3; ch++) begin
				carry_q[ch]  <= '0;
				pend_a_q[ch] <= '0;
				pend_b_q[ch] <= '0;
			end
		end else if (adv_s1) begin
			for (int ch = 0; ch < 3; ch++) begin
				carry_q[ch]  <= carry_n[ch];
				pend_a_q[ch] <= pa_n[ch];
				pend_b_q[ch] <= ERR_W'(e_v[ch]);
			end
		end
	end

	// last pixel of a row also leaves its below share in its own column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) endp_valid_q <= 1'b0;
		else endp_valid_q <= adv_s1 && last_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			endp_addr_q <= x_s1;
			endp_data_q <= {pa_n[2], pa_n[1], pa_n[0]};
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (adv_s1) valid_s2 <= 1'b1;
		else if (result.ready) valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			vertex_s2   <= vtx;
			red_on_s2   <= vbits[2] ^ invert_q;
			green_on_s2 <= vbits[1] ^ invert_q;
			blue_on_s2  <= vbits[0] ^ invert_q;
		end
	end

	assign result.valid    = valid_s2;
	assign result.vertex   = vertex_s2;
	assign result.red_on   = red_on_s2;
	assign result.green_on = green_on_s2;
	assign result.blue_on  = blue_on_s2;

	// ---------------------------------------------------------------- assertions
	// deferred end-of-row write never meets a stage 1 write on the single port
	a_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		endp_valid_q |-> !(adv_s1 && below_s1))
		else $error("line store write port conflict");

	// a row end always leaves its deferred write behind
	a_end_write: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> endp_valid_q)
		else $error("end-of-row write lost");

	// the clearing pass covers the whole line store
	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> ($past(clr_addr_q) == CW'(LINE_MAX - 1)))
		else $error("clearing pass ended early");

endmodule
